/* rtl/bpml_pkg.sv */
`timescale 1ns / 1ps

package bpml_pkg;

  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 7;
  localparam int LEN_W    = 8;
  localparam int LIMIT_W  = 16;
  localparam int OFFSET_W = 32;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [LIMIT_W-1:0] MAX_MATCHES = 16'd65535;

  localparam logic [LEN_W-1:0]   LEN_RESET   = 8'd80;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd255;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SCAN    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic {
    REG_PATTERN_LENGTH = 1'b0,
    REG_MATCH_LIMIT    = 1'b1
  } reg_idx_t;

  // pattern byte write
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
  } pat_wr_t;

  // window control
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

endpackage

/* rtl/byte_pattern_match_locator.sv */
`timescale 1ns / 1ps
// Each item passes the input register, and its result is then held in the result register on out_*.
// Throughput: one item per cycle; a result held by out_stall freezes the
//   input register, and in_stall rises once that register is also full.
// Reset (rst_n low, synchronous): clears valids, counters, stop flag and window
//   fill; pattern_length returns to 80 and match_limit to 255. Pattern bytes
//   are undefined until loaded.
module byte_pattern_match_locator #(
  parameter int MAX_PATTERN = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // item channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_op,
  input  logic [bpml_pkg::IDX_W-1:0]       in_pattern_index,
  input  logic [bpml_pkg::BYTE_W-1:0]      in_data_byte,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bpml_pkg::OFFSET_W-1:0]    out_match_offset,
  output logic [bpml_pkg::LIMIT_W-1:0]     out_match_number,
  output logic                             out_limit_reached,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bpml_pkg::APB_AW-1:0]      paddr,
  input  logic [bpml_pkg::APB_DW-1:0]      pwdata,
  output logic [bpml_pkg::APB_DW-1:0]      prdata,
  output logic                             pready
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int SH_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // configuration registers
  logic [bpml_pkg::LEN_W-1:0]   len_cfg_r;
  logic [bpml_pkg::LIMIT_W-1:0] limit_cfg_r;
  logic                         cfg_wr;

  // input register
  logic                         s1_valid_r;
  bpml_pkg::op_t                s1_op_r;
  logic [bpml_pkg::IDX_W-1:0]   s1_idx_r;
  logic [bpml_pkg::BYTE_W-1:0]  s1_data_r;
  logic                         in_take;
  logic                         adv;

  // search state
  logic [bpml_pkg::OFFSET_W-1:0] bytes_r, bytes_nxt;
  logic [bpml_pkg::LIMIT_W-1:0]  found_r, found_nxt;
  logic                          stopped_r, stopped_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic [bpml_pkg::OFFSET_W-1:0] out_offset_r;
  logic [bpml_pkg::LIMIT_W-1:0]  out_number_r;
  logic                          out_limit_r;
  logic                          emit;

  // datapath
  logic [8:0]                    len_ext;
  logic [LEN_W-1:0]              len_eff;
  logic [SH_W-1:0]               sh;
  logic [bpml_pkg::LIMIT_W-1:0]  lim_eff;
  logic [bpml_pkg::BYTE_W-1:0]   aligned [MAX_PATTERN];
  logic [bpml_pkg::BYTE_W-1:0]   win_nxt [MAX_PATTERN];
  logic [LEN_W-1:0]              fill_nxt;
  logic                          hit;
  bpml_pkg::pat_wr_t             pat_wr;
  bpml_pkg::win_ctl_t            win_ctl;

  // ---------------------------------------------------------------------
  // Register port: zero-wait, writes on the access phase
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r   <= bpml_pkg::LEN_RESET;
      limit_cfg_r <= bpml_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (bpml_pkg::reg_idx_t'(paddr[2]))
        bpml_pkg::REG_PATTERN_LENGTH: len_cfg_r   <= pwdata[bpml_pkg::LEN_W-1:0];
        bpml_pkg::REG_MATCH_LIMIT:    limit_cfg_r <= pwdata[bpml_pkg::LIMIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (bpml_pkg::reg_idx_t'(paddr[2]))
      bpml_pkg::REG_PATTERN_LENGTH: prdata = bpml_pkg::APB_DW'(len_cfg_r);
      bpml_pkg::REG_MATCH_LIMIT:    prdata = bpml_pkg::APB_DW'(limit_cfg_r);
    endcase
  end

  // ---------------------------------------------------------------------
  // Effective length and limit: clamp zero up to one, and large values
  // down to the store depth or the match ceiling
  // ---------------------------------------------------------------------
  assign len_ext = 9'(len_cfg_r);

  always_comb begin
    if (len_ext == 9'd0) begin
      len_eff = LEN_W'(1);
    end else if (len_ext > 9'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_ext[LEN_W-1:0];
    end
  end

  // shift that lines the reversed pattern up with the newest window bytes
  assign sh = SH_W'(9'(MAX_PATTERN) - 9'(len_eff));

  always_comb begin
    if (limit_cfg_r == '0) begin
      lim_eff = bpml_pkg::LIMIT_W'(1);
    end else if (limit_cfg_r > bpml_pkg::MAX_MATCHES) begin
      lim_eff = bpml_pkg::MAX_MATCHES;
    end else begin
      lim_eff = limit_cfg_r;
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: the input register advances whenever the result register
  // is empty or being drained; a waiting result holds it, and the input
  // stalls once it is full
  // ---------------------------------------------------------------------
  assign adv      = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload holds while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= bpml_pkg::op_t'(in_op);
      s1_idx_r  <= in_pattern_index;
      s1_data_r <= in_data_byte;
    end
  end

  // ---------------------------------------------------------------------
  // Pattern store, window and compare
  // ---------------------------------------------------------------------
  bpml_pattern #(.MAX_PATTERN(MAX_PATTERN)) u_pattern (
    .clk     (clk),
    .wr      (pat_wr),
    .sh      (sh),
    .aligned (aligned)
  );

  bpml_window #(.MAX_PATTERN(MAX_PATTERN)) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (win_ctl),
    .din      (s1_data_r),
    .win_nxt  (win_nxt),
    .fill_nxt (fill_nxt)
  );

  // compare against the window as it stands once this byte is in
  bpml_compare #(.MAX_PATTERN(MAX_PATTERN)) u_compare (
    .win     (win_nxt),
    .aligned (aligned),
    .len     (len_eff),
    .hit     (hit)
  );

  // ---------------------------------------------------------------------
  // Item decode and search state
  // ---------------------------------------------------------------------
  always_comb begin
    bytes_nxt     = bytes_r;
    found_nxt     = found_r;
    stopped_nxt   = stopped_r;
    emit          = 1'b0;
    pat_wr.en     = 1'b0;
    pat_wr.idx    = s1_idx_r;
    pat_wr.data   = s1_data_r;
    win_ctl.shift = 1'b0;
    win_ctl.clear = 1'b0;
    if (adv) begin
      unique case (s1_op_r)
        bpml_pkg::OP_LOAD: begin
          pat_wr.en = 1'b1;
        end
        bpml_pkg::OP_SCAN: begin
          // bytes keep counting and shifting in after the search stops
          win_ctl.shift = 1'b1;
          bytes_nxt     = bytes_r + bpml_pkg::OFFSET_W'(1);
          if (!stopped_r && (fill_nxt >= len_eff) && hit) begin
            if (found_r >= lim_eff) begin
              // match past the limit: stop quietly
              stopped_nxt = 1'b1;
            end else begin
              emit      = 1'b1;
              found_nxt = found_r + bpml_pkg::LIMIT_W'(1);
            end
          end
        end
        bpml_pkg::OP_RESTART: begin
          win_ctl.clear = 1'b1;
          bytes_nxt     = '0;
          found_nxt     = '0;
          stopped_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r   <= '0;
      found_r   <= '0;
      stopped_r <= 1'b0;
    end else begin
      bytes_r   <= bytes_nxt;
      found_r   <= found_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: hold until taken, reload on a new match
  // ---------------------------------------------------------------------
  assign out_valid_nxt = emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // offset of the first byte: current offset minus length less one, wrapping
  always_ff @(posedge clk) begin
    if (emit) begin
      out_offset_r <= bytes_r - bpml_pkg::OFFSET_W'(len_eff - LEN_W'(1));
      out_number_r <= found_nxt;
      out_limit_r  <= (found_nxt == lim_eff);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_offset  = out_offset_r;
  assign out_match_number  = out_number_r;
  assign out_limit_reached = out_limit_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a pending result always carries the current match count
  a_number_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_number_r == found_r))
    else $error("pending result number differs from match count");

  // the limit flag marks exactly the match that fills the limit
  a_limit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_limit_r) |-> (out_number_r == lim_eff))
    else $error("limit flag set below the match limit");

  // stopping the search never counts a match
  a_stop_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stopped_r) |-> (found_r == $past(found_r)))
    else $error("match counted on the stopping match");

endmodule

/* rtl/bpml_pattern.sv */
`timescale 1ns / 1ps

module bpml_pattern #(
  parameter int MAX_PATTERN = 128
) (
  input  logic                          clk,
  input  bpml_pkg::pat_wr_t             wr,
  input  logic [((MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1)-1:0] sh,
  output logic [bpml_pkg::BYTE_W-1:0]   aligned [MAX_PATTERN]
);

  localparam int SH_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [bpml_pkg::BYTE_W-1:0] pat_r [MAX_PATTERN];
  logic [bpml_pkg::BYTE_W-1:0] lvl [SH_W+1][MAX_PATTERN];
  logic [8:0]                  idx_ext;

  assign idx_ext = 9'(wr.idx);

  // drop writes beyond the store
  always_ff @(posedge clk) begin
    if (wr.en && (idx_ext < 9'(MAX_PATTERN))) begin
      pat_r[idx_ext[SH_W-1:0]] <= wr.data;
    end
  end

  // reverse the store, then shift down so that entry k faces pattern[len-1-k]
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      lvl[0][k] = pat_r[MAX_PATTERN-1-k];
    end
    for (int s = 0; s < SH_W; s++) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        if (!sh[s]) begin
          lvl[s+1][k] = lvl[s][k];
        end else if (k + (1 << s) < MAX_PATTERN) begin
          lvl[s+1][k] = lvl[s][k + (1 << s)];
        end else begin
          lvl[s+1][k] = '0;
        end
      end
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      aligned[k] = lvl[SH_W][k];
    end
  end

endmodule

/* rtl/bpml_window.sv */
`timescale 1ns / 1ps

module bpml_window #(
  parameter int MAX_PATTERN = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpml_pkg::win_ctl_t            ctl,
  input  logic [bpml_pkg::BYTE_W-1:0]   din,
  output logic [bpml_pkg::BYTE_W-1:0]   win_nxt [MAX_PATTERN],
  output logic [$clog2(MAX_PATTERN + 1)-1:0] fill_nxt
);

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);

  logic [bpml_pkg::BYTE_W-1:0] win_r [MAX_PATTERN];
  logic [FILL_W-1:0]           fill_r;

  // entry k holds the byte scanned k bytes ago
  always_comb begin
    win_nxt[0] = din;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  assign fill_nxt = (fill_r == FILL_W'(MAX_PATTERN)) ? fill_r : fill_r + FILL_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r <= win_nxt;
    end
  end

  // contents need no clear: the fill count gates every compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (ctl.clear) begin
      fill_r <= '0;
    end else if (ctl.shift) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

/* rtl/bpml_compare.sv */
`timescale 1ns / 1ps

module bpml_compare #(
  parameter int MAX_PATTERN = 128
) (
  input  logic [bpml_pkg::BYTE_W-1:0] win [MAX_PATTERN],
  input  logic [bpml_pkg::BYTE_W-1:0] aligned [MAX_PATTERN],
  input  logic [$clog2(MAX_PATTERN + 1)-1:0] len,
  output logic                        hit
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN-1:0] eq;

  // positions at or past the length always agree
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      eq[k] = ((LEN_W+1)'(k) >= (LEN_W+1)'(len)) || (win[k] == aligned[k]);
    end
  end

  assign hit = &eq;

endmodule

/* tb/byte_pattern_match_locator_tb.sv */
`timescale 1ns / 1ps

module byte_pattern_match_locator_tb;

  // op code with no function in the block; it must be swallowed silently
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int WIN_DEPTH     = 128;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 85;
  localparam int DRAIN_CYCLES  = 4;

  typedef struct packed {
    logic [bpml_pkg::OFFSET_W-1:0] offset;
    logic [bpml_pkg::LIMIT_W-1:0]  number;
    logic                          limit_hit;
  } match_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    in_op;
  logic [bpml_pkg::IDX_W-1:0]    in_pattern_index;
  logic [bpml_pkg::BYTE_W-1:0]   in_data_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [bpml_pkg::OFFSET_W-1:0] out_match_offset;
  logic [bpml_pkg::LIMIT_W-1:0]  out_match_number;
  logic                          out_limit_reached;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [bpml_pkg::APB_AW-1:0]   paddr;
  logic [bpml_pkg::APB_DW-1:0]   pwdata;
  logic [bpml_pkg::APB_DW-1:0]   prdata;
  logic                          pready;

  // Search state mirrored on the testbench side
  logic [bpml_pkg::BYTE_W-1:0]   pattern_mem [WIN_DEPTH];
  logic [bpml_pkg::BYTE_W-1:0]   window [WIN_DEPTH];
  int                            win_fill;
  logic [bpml_pkg::OFFSET_W-1:0] bytes_seen;
  logic [bpml_pkg::LIMIT_W-1:0]  found;
  logic                          stopped;
  logic [bpml_pkg::LEN_W-1:0]    plen;
  logic [bpml_pkg::LIMIT_W-1:0]  mlimit;

  // Matches predicted but not yet seen on the result channel, oldest first
  match_t due_matches [$];

  int errors;
  int cycle_count;
  int send_gap_pct;   // chance in percent that the sender idles before an item
  int stall_pct;      // chance in percent that the receiver starts a stall burst
  int hold_cycles;    // request for one long receiver hold-off

  byte_pattern_match_locator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_pattern_index  (in_pattern_index),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_match_offset  (out_match_offset),
    .out_match_number  (out_match_number),
    .out_limit_reached (out_limit_reached),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Pattern length as the block applies it: zero acts as one, anything
  // above the window depth acts as the full window.
  function automatic int active_length();
    if (plen == 0) return 1;
    if (plen > WIN_DEPTH) return WIN_DEPTH;
    return int'(plen);
  endfunction

  // Restart and reset both empty the window and reopen the search
  function automatic void clear_search();
    for (int k = 0; k < WIN_DEPTH; k++) window[k] = '0;
    win_fill   = 0;
    bytes_seen = '0;
    found      = '0;
    stopped    = 1'b0;
  endfunction

  // Apply one accepted item to the mirrored search state and queue the
  // match it reports, if any.
  function automatic void advance_search(logic [1:0] op,
                                         logic [bpml_pkg::IDX_W-1:0] idx,
                                         logic [bpml_pkg::BYTE_W-1:0] data);
    int                            len;
    int                            lim;
    logic [bpml_pkg::OFFSET_W-1:0] offset;
    bit                            equal;
    match_t                        m;
    case (op)
      bpml_pkg::OP_LOAD: begin
        pattern_mem[idx] = data;
      end
      bpml_pkg::OP_RESTART: begin
        clear_search();
      end
      bpml_pkg::OP_SCAN: begin
        // Shift the newest byte in at entry zero
        for (int k = WIN_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
        window[0] = data;
        if (win_fill < WIN_DEPTH) win_fill++;
        offset     = bytes_seen;
        bytes_seen = bytes_seen + 1'b1;
        len = active_length();
        lim = (mlimit == 0) ? 1 : int'(mlimit);
        if (!stopped && win_fill >= len) begin
          // Oldest window byte lines up with pattern entry zero
          equal = 1'b1;
          for (int k = 0; k < len; k++)
            if (window[k] != pattern_mem[len-1-k]) equal = 1'b0;
          if (equal) begin
            if (found >= lim) begin
              // one match beyond the limit: drop it and freeze the search
              stopped = 1'b1;
            end else begin
              found       = found + 1'b1;
              m.offset    = offset - bpml_pkg::OFFSET_W'(len - 1);
              m.number    = found;
              m.limit_hit = (found == lim);
              due_matches.push_back(m);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one item and hold it until accepted. Entered and left at a
  // falling edge; valid stays high on exit so back-to-back items need no
  // toggle.
  task automatic send_item(input logic [1:0] op, input logic [bpml_pkg::IDX_W-1:0] idx,
                           input logic [bpml_pkg::BYTE_W-1:0] data);
    int gap;
    gap = 0;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
      gap = $urandom_range(1, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_pattern_index <= idx;
    in_data_byte     <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_search(op, idx, data);
    @(negedge clk);
  endtask

  // Drop valid, wait for every predicted match, then let the pipeline empty
  // of items that report nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_matches.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic cfg_write(input bpml_pkg::reg_idx_t which,
                           input logic [bpml_pkg::APB_DW-1:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (which)
      bpml_pkg::REG_PATTERN_LENGTH: plen   = value[bpml_pkg::LEN_W-1:0];
      bpml_pkg::REG_MATCH_LIMIT:    mlimit = value[bpml_pkg::LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly one of two symbols, so short patterns match often
  function automatic logic [bpml_pkg::BYTE_W-1:0] pick_symbol(
      logic [bpml_pkg::BYTE_W-1:0] sym_a, logic [bpml_pkg::BYTE_W-1:0] sym_b);
    if ($urandom_range(0, 9) == 0) return bpml_pkg::BYTE_W'($urandom_range(0, 255));
    return $urandom_range(0, 1) ? sym_a : sym_b;
  endfunction

  task automatic scan_byte(input logic [bpml_pkg::BYTE_W-1:0] data);
    send_item(bpml_pkg::OP_SCAN, bpml_pkg::IDX_W'($urandom_range(0, 127)), data);
  endtask

  // Fill every pattern entry so no compare ever touches an unloaded one
  task automatic test_pattern_load();
    for (int k = 0; k < WIN_DEPTH; k++)
      send_item(bpml_pkg::OP_LOAD, bpml_pkg::IDX_W'(k),
                bpml_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // Short stream, overlapping matches, extreme bytes, reload mid-stream,
  // unused op
  task automatic test_directed();
    cfg_write(bpml_pkg::REG_PATTERN_LENGTH, 3);
    cfg_write(bpml_pkg::REG_MATCH_LIMIT, 255);
    send_item(bpml_pkg::OP_RESTART, '0, '0);
    for (int k = 0; k < 3; k++) send_item(bpml_pkg::OP_LOAD, bpml_pkg::IDX_W'(k), 8'h00);
    // a zero pattern must not match the cleared window before three bytes
    repeat (4) scan_byte(8'h00);
    scan_byte(8'hFF);
    send_item(OP_UNUSED, 7'h7F, 8'hFF);
    for (int k = 0; k < 3; k++) send_item(bpml_pkg::OP_LOAD, bpml_pkg::IDX_W'(k), 8'hFF);
    repeat (2) scan_byte(8'hFF);
    send_item(bpml_pkg::OP_RESTART, 7'h7F, 8'hFF);
    scan_byte(8'h00);
    repeat (3) scan_byte(8'hFF);
  endtask

  // Limit of one, zero limit, zero length, lowering the limit under the count
  task automatic test_limits();
    cfg_write(bpml_pkg::REG_PATTERN_LENGTH, 0);
    cfg_write(bpml_pkg::REG_MATCH_LIMIT, 1);
    send_item(bpml_pkg::OP_LOAD, '0, 8'h5A);
    send_item(bpml_pkg::OP_RESTART, '0, '0);
    repeat (3) scan_byte(8'h5A);
    send_item(bpml_pkg::OP_RESTART, '0, '0);
    scan_byte(8'h5A);
    cfg_write(bpml_pkg::REG_MATCH_LIMIT, 0);
    send_item(bpml_pkg::OP_RESTART, '0, '0);
    repeat (2) scan_byte(8'h5A);
    cfg_write(bpml_pkg::REG_MATCH_LIMIT, 5);
    send_item(bpml_pkg::OP_RESTART, '0, '0);
    repeat (3) scan_byte(8'h5A);
    cfg_write(bpml_pkg::REG_MATCH_LIMIT, 2);
    repeat (2) scan_byte(8'h5A);
  endtask

  // Full-window pattern, and an oversized length that acts as the full window
  task automatic test_long_pattern();
    cfg_write(bpml_pkg::REG_PATTERN_LENGTH, WIN_DEPTH);
    cfg_write(bpml_pkg::REG_MATCH_LIMIT, 255);
    send_item(bpml_pkg::OP_RESTART, '0, '0);
    repeat (5) scan_byte(bpml_pkg::BYTE_W'($urandom_range(0, 255)));
    repeat (2)
      for (int k = 0; k < WIN_DEPTH; k++) scan_byte(pattern_mem[k]);
    cfg_write(bpml_pkg::REG_PATTERN_LENGTH, 255);
    send_item(bpml_pkg::OP_RESTART, '0, '0);
    for (int k = 0; k < WIN_DEPTH; k++) scan_byte(pattern_mem[k]);
    repeat (3) scan_byte(bpml_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // Hold the result side for a long stretch while every byte matches,
  // so the block backs up and stalls its input
  task automatic test_backpressure();
    cfg_write(bpml_pkg::REG_PATTERN_LENGTH, 1);
    cfg_write(bpml_pkg::REG_MATCH_LIMIT, bpml_pkg::MAX_MATCHES);
    send_item(bpml_pkg::OP_LOAD, '0, 8'h3C);
    send_item(bpml_pkg::OP_RESTART, '0, '0);
    hold_cycles = 80;
    repeat (40) scan_byte(8'h3C);
  endtask

  // One random setting followed by a stream that plants the pattern often
  task automatic random_phase(input int quota);
    int                          len_cfg;
    int                          lim_cfg;
    int                          len_eff;
    int                          sent;
    int                          pick;
    logic [bpml_pkg::BYTE_W-1:0] sym_a;
    logic [bpml_pkg::BYTE_W-1:0] sym_b;
    pick = $urandom_range(0, 9);
    if (pick < 7)       len_cfg = $urandom_range(1, 4);
    else if (pick == 7) len_cfg = $urandom_range(5, 16);
    else if (pick == 8) len_cfg = $urandom_range(17, WIN_DEPTH);
    else                len_cfg = $urandom_range(0, 1) ? 0 : $urandom_range(129, 255);
    pick = $urandom_range(0, 9);
    if (pick < 4)       lim_cfg = $urandom_range(50, 1000);
    else if (pick < 6)  lim_cfg = bpml_pkg::MAX_MATCHES;
    else if (pick < 8)  lim_cfg = $urandom_range(1, 8);
    else if (pick == 8) lim_cfg = 0;
    else                lim_cfg = $urandom_range(0, 65535);
    cfg_write(bpml_pkg::REG_PATTERN_LENGTH, len_cfg);
    cfg_write(bpml_pkg::REG_MATCH_LIMIT, lim_cfg);
    len_eff = active_length();
    sym_a   = bpml_pkg::BYTE_W'($urandom_range(0, 255));
    sym_b   = bpml_pkg::BYTE_W'($urandom_range(0, 255));
    for (int k = 0; k < len_eff; k++)
      send_item(bpml_pkg::OP_LOAD, bpml_pkg::IDX_W'(k), pick_symbol(sym_a, sym_b));
    send_item(bpml_pkg::OP_RESTART, bpml_pkg::IDX_W'($urandom_range(0, 127)),
              bpml_pkg::BYTE_W'($urandom_range(0, 255)));
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // plant a whole copy of the pattern
        for (int k = 0; k < len_eff; k++) scan_byte(pattern_mem[k]);
        sent += len_eff;
      end else if (pick < 85) begin
        scan_byte(pick_symbol(sym_a, sym_b));
        sent++;
      end else if (pick < 92) begin
        send_item(bpml_pkg::OP_LOAD, bpml_pkg::IDX_W'($urandom_range(0, len_eff - 1)),
                  pick_symbol(sym_a, sym_b));
        sent++;
      end else if (pick < 97) begin
        send_item(bpml_pkg::OP_RESTART, bpml_pkg::IDX_W'($urandom_range(0, 127)),
                  bpml_pkg::BYTE_W'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_item(OP_UNUSED, bpml_pkg::IDX_W'($urandom_range(0, 127)),
                  bpml_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_random();
    int mode;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = $urandom_range(0, 2);
      // last phases run with no idling on either side
      if (phase >= RANDOM_PHASES - 2) begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end else begin
        send_gap_pct = (mode == 0) ? 0 : (mode == 1) ? 15 : 40;
        stall_pct    = (mode == 2) ? 0 : (mode == 1) ? 40 : 15;
      end
      random_phase(PHASE_ITEMS);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest predicted match
  match_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_matches.size() == 0) begin
        $display("%0t: unexpected match: expected none, actual offset %h number %0d",
                 $time, out_match_offset, out_match_number);
        errors++;
      end else begin
        want = due_matches.pop_front();
        if (out_match_offset !== want.offset) begin
          $display("%0t: match_offset expected %h actual %h",
                   $time, want.offset, out_match_offset);
          errors++;
        end
        if (out_match_number !== want.number) begin
          $display("%0t: match_number expected %0d actual %0d",
                   $time, want.number, out_match_number);
          errors++;
        end
        if (out_limit_reached !== want.limit_hit) begin
          $display("%0t: limit_reached expected %b actual %b",
                   $time, want.limit_hit, out_limit_reached);
          errors++;
        end
      end
    end
  end

  initial begin
    in_valid         = 1'b0;
    in_op            = bpml_pkg::OP_LOAD;
    in_pattern_index = '0;
    in_data_byte     = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    rst_n            = 1'b0;
    errors           = 0;
    cycle_count      = 0;
    hold_cycles      = 0;
    send_gap_pct     = 20;
    stall_pct        = 20;
    plen             = bpml_pkg::LEN_RESET;
    mlimit           = bpml_pkg::LIMIT_RESET;
    clear_search();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_pattern_load();
    test_directed();
    test_limits();
    test_long_pattern();
    test_backpressure();
    test_random();

    settle();
    repeat (10) @(negedge clk);
    if (errors == 0 && due_matches.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bpml_pkg.sv
rtl/bpml_pattern.sv
rtl/bpml_window.sv
rtl/bpml_compare.sv
rtl/byte_pattern_match_locator.sv
tb/byte_pattern_match_locator_tb.sv
